[hw/rtl/pmcc_pkg.sv]
// ----------------------------------------------------------------------------
// pmcc_pkg
// Shared types, register indexes, error codes and the CRC-32 lookup table
// for the packet magic-word and CRC checker.
// ----------------------------------------------------------------------------
package pmcc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Byte count saturates at 2^LENGTH_BITS, one above the largest length register.
    localparam int LENGTH_BITS = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_ENABLE   = 3'd4;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_TOO_SHORT = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
    localparam logic [2:0] ERR_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ERR_BAD_CRC   = 3'd4;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic                 accepted;
        logic [2:0]           error_code;
        logic [LENGTH_BITS:0] packet_length;
        logic [31:0]          computed_crc;
    } t_out_item;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] max_length;
        logic [15:0] min_length;
        logic        magic_enable;
        logic        crc_enable;
    } t_cfg;

    typedef logic [31:0] t_crc_table [0:255];

    // Bytewise table for the reflected polynomial, built at elaboration.
    function automatic t_crc_table f_crc_table();
        t_crc_table  tab;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam t_crc_table CRC_TABLE = f_crc_table();

endpackage

[hw/rtl/pmcc_cfg.sv]
// ----------------------------------------------------------------------------
// pmcc_cfg
// Configuration register bank: decodes plain writes by index.
// ----------------------------------------------------------------------------
module pmcc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pmcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pmcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pmcc_pkg::t_cfg                   o_cfg
);

    pmcc_pkg::t_cfg r_cfg;
    pmcc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmcc_pkg::CFG_MAGIC_WORD:   n_cfg.magic_word   = i_cfg_data;
                pmcc_pkg::CFG_MAX_LENGTH:   n_cfg.max_length   = i_cfg_data[15:0];
                pmcc_pkg::CFG_MIN_LENGTH:   n_cfg.min_length   = i_cfg_data[15:0];
                pmcc_pkg::CFG_MAGIC_ENABLE: n_cfg.magic_enable = i_cfg_data[0];
                pmcc_pkg::CFG_CRC_ENABLE:   n_cfg.crc_enable   = i_cfg_data[0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word   <= 32'd0;
            r_cfg.max_length   <= 16'd65535;
            r_cfg.min_length   <= 16'd8;
            r_cfg.magic_enable <= 1'b1;
            r_cfg.crc_enable   <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/pmcc_core.sv]
// ----------------------------------------------------------------------------
// pmcc_core
// Per-packet state (CRC, trailer delay line, magic capture, byte count)
// and the verdict logic applied on the last byte.
// ----------------------------------------------------------------------------
module pmcc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  pmcc_pkg::t_in_item  i_item,
    input  pmcc_pkg::t_cfg      i_cfg,
    output logic                o_done,
    output pmcc_pkg::t_out_item o_result
);

    localparam int CW = pmcc_pkg::LENGTH_BITS + 1;
    localparam int XW = (CW > 17) ? CW : 17;
    localparam logic [CW-1:0] CAP = CW'(1) << pmcc_pkg::LENGTH_BITS;

    logic [31:0]     r_acc,   n_acc;
    logic [3:0][7:0] r_delay, n_delay;
    logic [31:0]     r_magic, n_magic;
    logic [CW-1:0]   r_count, n_count;

    logic [7:0]    tab_idx;
    logic [31:0]   crc_out;
    logic [31:0]   trailer;
    logic [XW-1:0] count_x;
    logic          short4;
    logic [2:0]    code;

    always_comb begin
        // Advance the oldest held byte into the CRC once four newer ones exist.
        tab_idx = r_acc[7:0] ^ r_delay[0];
        n_acc   = r_acc;
        if (r_count >= CW'(4)) begin
            n_acc = (r_acc >> 8) ^ pmcc_pkg::CRC_TABLE[tab_idx];
        end

        n_magic = r_magic;
        if (r_count < CW'(4)) begin
            case (r_count[1:0])
                2'd0:    n_magic[7:0]   = i_item.data_byte;
                2'd1:    n_magic[15:8]  = i_item.data_byte;
                2'd2:    n_magic[23:16] = i_item.data_byte;
                default: n_magic[31:24] = i_item.data_byte;
            endcase
        end

        n_delay = {i_item.data_byte & pmcc_pkg::BYTE_MASK, r_delay[3:1]};
        n_count = (r_count < CAP) ? r_count + CW'(1) : r_count;

        trailer = n_delay;
        crc_out = n_acc ^ pmcc_pkg::CRC_ALL_ONES;
        count_x = XW'(n_count);
        short4  = n_count < CW'(4);

        if (count_x < XW'(i_cfg.min_length)) begin
            code = pmcc_pkg::ERR_TOO_SHORT;
        end else if (count_x > XW'(i_cfg.max_length)) begin
            code = pmcc_pkg::ERR_TOO_LONG;
        end else if (i_cfg.magic_enable && (short4 || n_magic != i_cfg.magic_word)) begin
            code = pmcc_pkg::ERR_BAD_MAGIC;
        end else if (i_cfg.crc_enable && (short4 || trailer != crc_out)) begin
            code = pmcc_pkg::ERR_BAD_CRC;
        end else begin
            code = pmcc_pkg::ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.end_of_packet)) begin
            r_acc   <= pmcc_pkg::CRC_ALL_ONES;
            r_delay <= '0;
            r_magic <= 32'd0;
            r_count <= '0;
        end else if (i_step) begin
            r_acc   <= n_acc;
            r_delay <= n_delay;
            r_magic <= n_magic;
            r_count <= n_count;
        end
    end

    assign o_done                 = i_step && i_item.end_of_packet;
    assign o_result.accepted      = (code == pmcc_pkg::ERR_OK);
    assign o_result.error_code    = code;
    assign o_result.packet_length = count_x[CW-1:0];
    assign o_result.computed_crc  = crc_out;

endmodule

[hw/rtl/packet_magic_crc_checker.sv]
// ----------------------------------------------------------------------------
// packet_magic_crc_checker
// Byte-stream packet checker: length window, magic word and CRC-32 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one packet byte per request with an end-of-packet
//   flag on the last byte. One verdict request leaves the output channel per
//   packet: accepted flag, error code, byte count and the computed CRC-32.
//   Checks run in order: too short, too long, magic word, CRC trailer; the
//   first failing one sets the code.
//   Throughput: one byte per cycle while the input is not stalled, set by the
//   bytewise CRC table update between the input and verdict registers.
//   A last byte lands in the input register, and the verdict register loads
//   from it once the output register is free.
//   Stall: a waiting verdict holds in the output register; middle bytes keep
//   flowing, and only a last byte waits in the input register until the
//   output register frees, which stalls the input side.
//   Reset: synchronous, active low; registers return to their defaults
//   (magic 0, max 65535, min 8, both checks enabled) and packet state clears.
//   Configuration is written through a plain index/data port; the user must
//   write it only while idle, and the block itself leaves this unchecked.
// ----------------------------------------------------------------------------
module packet_magic_crc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pmcc_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pmcc_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [pmcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pmcc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pmcc_pkg::t_cfg      cfg;
    pmcc_pkg::t_in_item  r_s1;
    logic                r_s1_valid, n_s1_valid;
    pmcc_pkg::t_out_item r_out;
    logic                r_out_valid, n_out_valid;
    pmcc_pkg::t_out_item result;
    logic                done;
    logic                out_free;
    logic                s1_go;
    logic                in_take;

    pmcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Output register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    // Middle bytes always advance; a last byte needs room for its verdict.
    assign s1_go      = r_s1_valid && (!r_s1.end_of_packet || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    pmcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_go),
        .i_item   (r_s1),
        .i_cfg    (cfg),
        .o_done   (done),
        .o_result (result)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control flags take reset; payload registers load without it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= i_in_data;
        end
        if (done) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/pmcc_checker.sv]
// ----------------------------------------------------------------------------
// pmcc_checker
// Port-level assertions for the packet checker, bound to the top level.
// ----------------------------------------------------------------------------
module pmcc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pmcc_pkg::t_out_item o_out_data
);

    // Hold a stalled verdict unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("verdict changed while stalled");

    // Drop any pending verdict on reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict valid after reset");

    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.accepted == (o_out_data.error_code == pmcc_pkg::ERR_OK)))
        else $error("accepted flag disagrees with error code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.error_code <= pmcc_pkg::ERR_BAD_CRC))
        else $error("error code out of range");

endmodule

bind packet_magic_crc_checker pmcc_checker u_pmcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[verif/packet_magic_crc_checker_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_magic_crc_checker_monitor
// Watches both channels and the register port of the packet checker, keeps
// its own copy of the packet state and registers, and compares every verdict
// with the one it works out from the accepted bytes.
// ----------------------------------------------------------------------------
module packet_magic_crc_checker_monitor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  pmcc_pkg::t_in_item               i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  pmcc_pkg::t_out_item              i_out_data,
    input  logic                             i_cfg_we,
    input  logic [pmcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pmcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_outstanding,
    output int                               o_failures
);

    localparam logic [16:0] LENGTH_CAP = 17'h1_0000;

    pmcc_pkg::t_cfg      regs;
    logic [31:0]         crc_acc;
    logic [7:0]          tail [4];
    logic [31:0]         head_word;
    logic [16:0]         byte_count;
    pmcc_pkg::t_out_item verdicts_due [$];
    pmcc_pkg::t_out_item due;
    logic [31:0]         trailer;
    logic [31:0]         crc_out;
    logic [2:0]          code;
    logic [7:0]          b;
    int                  fail_count = 0;

    function automatic logic [31:0] crc_shift_byte(input logic [31:0] acc,
                                                   input logic [7:0] d);
        logic [31:0] c;
        c = acc ^ {24'd0, d};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ pmcc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_packet_state();
        crc_acc    = pmcc_pkg::CRC_ALL_ONES;
        tail       = '{default: 8'd0};
        head_word  = 32'd0;
        byte_count = 17'd0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '{magic_word: 32'd0, max_length: 16'hFFFF, min_length: 16'd8,
                     magic_enable: 1'b1, crc_enable: 1'b1};
            clear_packet_state();
            verdicts_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pmcc_pkg::CFG_MAGIC_WORD:   regs.magic_word   = i_cfg_data;
                    pmcc_pkg::CFG_MAX_LENGTH:   regs.max_length   = i_cfg_data[15:0];
                    pmcc_pkg::CFG_MIN_LENGTH:   regs.min_length   = i_cfg_data[15:0];
                    pmcc_pkg::CFG_MAGIC_ENABLE: regs.magic_enable = i_cfg_data[0];
                    pmcc_pkg::CFG_CRC_ENABLE:   regs.crc_enable   = i_cfg_data[0];
                    default: ;
                endcase
            end

            // compare a delivered verdict with the oldest one due
            if (i_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    $error("verdict with none due: code %0d, length %0d",
                           i_out_data.error_code, i_out_data.packet_length);
                    fail_count++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (i_out_data.accepted !== due.accepted) begin
                        $error("accepted: expected %0d, got %0d",
                               due.accepted, i_out_data.accepted);
                        fail_count++;
                    end
                    if (i_out_data.error_code !== due.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               due.error_code, i_out_data.error_code);
                        fail_count++;
                    end
                    if (i_out_data.packet_length !== due.packet_length) begin
                        $error("packet_length: expected %0d, got %0d",
                               due.packet_length, i_out_data.packet_length);
                        fail_count++;
                    end
                    if (i_out_data.computed_crc !== due.computed_crc) begin
                        $error("computed_crc: expected %08h, got %08h",
                               due.computed_crc, i_out_data.computed_crc);
                        fail_count++;
                    end
                end
            end

            // advance the packet state by one accepted byte
            if (i_in_valid && !i_in_stall) begin
                b = i_in_data.data_byte;
                if (byte_count >= 17'd4) begin
                    crc_acc = crc_shift_byte(crc_acc, tail[0]);
                end else begin
                    head_word = head_word | ({24'd0, b} << (8 * byte_count));
                end
                tail[0] = tail[1];
                tail[1] = tail[2];
                tail[2] = tail[3];
                tail[3] = b;
                if (byte_count < LENGTH_CAP) begin
                    byte_count++;
                end

                if (i_in_data.end_of_packet) begin
                    trailer = {tail[3], tail[2], tail[1], tail[0]};
                    crc_out = crc_acc ^ pmcc_pkg::CRC_ALL_ONES;
                    if (byte_count < {1'b0, regs.min_length}) begin
                        code = pmcc_pkg::ERR_TOO_SHORT;
                    end else if (byte_count > {1'b0, regs.max_length}) begin
                        code = pmcc_pkg::ERR_TOO_LONG;
                    end else if (regs.magic_enable &&
                                 (byte_count < 17'd4 || head_word != regs.magic_word)) begin
                        code = pmcc_pkg::ERR_BAD_MAGIC;
                    end else if (regs.crc_enable &&
                                 (byte_count < 17'd4 || trailer != crc_out)) begin
                        code = pmcc_pkg::ERR_BAD_CRC;
                    end else begin
                        code = pmcc_pkg::ERR_OK;
                    end
                    verdicts_due.push_back('{accepted: (code == pmcc_pkg::ERR_OK),
                                             error_code: code,
                                             packet_length: byte_count,
                                             computed_crc: crc_out});
                    clear_packet_state();
                end
            end
        end
        o_outstanding <= verdicts_due.size();
        o_failures    <= fail_count;
    end

endmodule

[verif/packet_magic_crc_checker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_magic_crc_checker_test
// Drives framed and malformed byte packets into the packet checker under
// several register settings, with random gaps and stalls on both sides, and
// reports the verdict of the monitor that checks every result.
// ----------------------------------------------------------------------------
module packet_magic_crc_checker_test;

    // Writes here must be dropped by the block.
    localparam logic [pmcc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int TIMEOUT_NS  = 20_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 38;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    pmcc_pkg::t_in_item               in_data = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    pmcc_pkg::t_out_item              out_data;
    logic                             cfg_we = 1'b0;
    logic [pmcc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pmcc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int             outstanding;
    int             failures;
    bit             idling = 1'b1;    // random gaps and stalls on both sides
    bit             hold_req = 1'b0;  // ask the receiver for one long hold-off
    bit             hold_done = 1'b0; // the receiver has served the hold-off
    pmcc_pkg::t_cfg live_cfg;
    logic [7:0]     packet_bytes [$];

    always #5 clk = ~clk;

    packet_magic_crc_checker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    packet_magic_crc_checker_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_failures    (failures)
    );

    // Offer one byte request and hold it until the block takes it. Idle
    // cycles go before the request, so valid only ever drops between bytes.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        @(negedge clk);
        while (idling && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_packet: eop};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic lower_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Drain every verdict, then give the pipeline its latency to go quiet.
    task automatic settle();
        lower_valid();
        wait (outstanding == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pmcc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pmcc_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic set_cfg(input logic [31:0] magic, input logic [15:0] max_len,
                           input logic [15:0] min_len, input bit magic_en,
                           input bit crc_en);
        settle();
        write_reg(CFG_UNUSED_INDEX, $urandom());
        write_reg(pmcc_pkg::CFG_MAGIC_WORD, magic);
        write_reg(pmcc_pkg::CFG_MAX_LENGTH, {16'($urandom_range(65535)), max_len});
        write_reg(pmcc_pkg::CFG_MIN_LENGTH, {16'($urandom_range(65535)), min_len});
        write_reg(pmcc_pkg::CFG_MAGIC_ENABLE, {31'd0, magic_en});
        write_reg(pmcc_pkg::CFG_CRC_ENABLE, {31'd0, crc_en});
        cfg_we <= 1'b0;
        live_cfg = '{magic_word: magic, max_length: max_len, min_length: min_len,
                     magic_enable: magic_en, crc_enable: crc_en};
    endtask

    // Build a well-formed packet: magic word, random body, CRC trailer.
    // Spoil flips one trailer bit. Needs len of at least eight.
    task automatic frame_packet(input int len, input logic [31:0] magic, input bit spoil);
        logic [31:0] crc;
        logic [7:0]  b;
        packet_bytes.delete();
        crc = pmcc_pkg::CRC_ALL_ONES;
        for (int i = 0; i < len - 4; i++) begin
            b = (i < 4) ? magic[8*i +: 8] : 8'($urandom());
            packet_bytes.push_back(b);
            crc = (crc >> 8) ^ pmcc_pkg::CRC_TABLE[crc[7:0] ^ b];
        end
        crc = crc ^ pmcc_pkg::CRC_ALL_ONES;
        if (spoil) crc = crc ^ (32'd1 << $urandom_range(31));
        for (int i = 0; i < 4; i++) packet_bytes.push_back(crc[8*i +: 8]);
    endtask

    task automatic noise_packet(input int len);
        packet_bytes.delete();
        repeat (len) packet_bytes.push_back(8'($urandom()));
    endtask

    task automatic send_packet();
        for (int i = 0; i < packet_bytes.size(); i++) begin
            send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
        end
    endtask

    // Receiver: random stalls, or one long counted hold-off on request.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_stall <= idling && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int          phase_bytes;
        int          pick;
        logic [31:0] magic;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        live_cfg = '{magic_word: 32'd0, max_length: 16'hFFFF, min_length: 16'd8,
                     magic_enable: 1'b1, crc_enable: 1'b1};

        // Reset settings: good, bad trailer, bad magic, one byte short.
        frame_packet(8, 32'd0, 1'b0);
        send_packet();
        frame_packet(16, 32'd0, 1'b1);
        send_packet();
        frame_packet(12, 32'd1, 1'b0);
        send_packet();
        noise_packet(7);
        send_packet();

        // Packets under four bytes fail the magic check; four all-ones bytes
        // match the magic but not the empty CRC.
        set_cfg(32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b1, 1'b1);
        for (int len = 1; len <= 3; len++) begin
            noise_packet(len);
            send_packet();
        end
        packet_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        frame_packet(9, 32'hFFFF_FFFF, 1'b0);
        send_packet();

        // Magic skipped: short packets now fail the CRC, four zero bytes pass.
        set_cfg($urandom(), 16'hFFFF, 16'd0, 1'b0, 1'b1);
        noise_packet(2);
        send_packet();
        packet_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        frame_packet(10, ~live_cfg.magic_word, 1'b0);
        send_packet();

        // Both checks off: anything inside the length window passes.
        set_cfg($urandom(), 16'hFFFF, 16'd0, 1'b0, 1'b0);
        noise_packet(1);
        send_packet();
        noise_packet(20);
        send_packet();

        // Length extremes: too short wins over too long.
        set_cfg(32'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1);
        noise_packet(3);
        send_packet();
        set_cfg(32'd0, 16'd0, 16'd0, 1'b1, 1'b1);
        noise_packet(1);
        send_packet();

        // Window edges at eight and twelve bytes.
        set_cfg($urandom(), 16'd12, 16'd8, 1'b1, 1'b1);
        frame_packet(8, live_cfg.magic_word, 1'b0);
        send_packet();
        frame_packet(12, live_cfg.magic_word, 1'b0);
        send_packet();
        frame_packet(13, live_cfg.magic_word, 1'b0);
        send_packet();
        noise_packet(7);
        send_packet();

        // Random phases, mostly framed packets under fresh settings.
        for (int phase = 0; phase < 5; phase++) begin
            case ($urandom_range(3))
                0:       magic = 32'd0;
                1:       magic = 32'hFFFF_FFFF;
                default: magic = $urandom();
            endcase
            set_cfg(magic,
                    $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(16, 48)),
                    16'($urandom_range(10)),
                    $urandom_range(99) < 80, $urandom_range(99) < 80);
            idling = (phase != 2);

            // Hold the receiver off while short packets keep coming, so the
            // block fills and stalls its input; then wait for every verdict.
            if (phase == 1) begin
                hold_req = 1'b1;
                repeat (8) begin
                    noise_packet($urandom_range(1, 3));
                    send_packet();
                end
                lower_valid();
                wait (outstanding == 0);
            end

            phase_bytes = 0;
            while (phase_bytes < 400) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    frame_packet($urandom_range(8, 40), live_cfg.magic_word, 1'b0);
                end else if (pick < 72) begin
                    frame_packet($urandom_range(8, 40), live_cfg.magic_word, 1'b1);
                end else if (pick < 82) begin
                    frame_packet($urandom_range(8, 40),
                                 live_cfg.magic_word ^ (32'd1 << $urandom_range(31)), 1'b0);
                end else if (pick < 92) begin
                    noise_packet($urandom_range(1, 12));
                end else begin
                    frame_packet($urandom_range(41, 70), live_cfg.magic_word, 1'b0);
                end
                send_packet();
                phase_bytes += packet_bytes.size();
                if ($urandom_range(99) < 4) begin
                    lower_valid();
                    wait (outstanding == 0);
                end
            end
        end
        idling = 1'b1;

        // Drain, then watch a few more cycles for stray verdicts.
        lower_valid();
        wait (outstanding == 0);
        repeat (8) @(negedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("packet_magic_crc_checker test passed");
        end else begin
            $display("packet_magic_crc_checker test failed");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("packet_magic_crc_checker test failed");
        $finish;
    end

endmodule
